/* design/bxavg_pkg.sv */
`default_nettype none

package bxavg_pkg;

  // Pixel channel width and channel count
  localparam int PIX_W = 8;
  localparam int CH_N  = 3;

  // Default size limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_FACTOR_DEF = 16;

  // Configuration port
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 11;
  localparam int FACTOR_REG_W = 5;
  localparam int WIDTH_REG_W  = 11;

  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_FACTOR = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd1;

  localparam logic [FACTOR_REG_W-1:0] FACTOR_RESET = 5'd2;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd512;

  // Commands from controller to datapath
  typedef struct packed {
    logic pix_accept;
    logic div_start;
    logic div_cfg;
    logic cfg_load;
    logic out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic rd_ok;
    logic out_fire;
    logic div_busy;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* design/bxavg_if.sv */
`default_nettype none

interface bxavg_pix_if;
  logic                         valid;
  logic                         ready;
  logic                         frame_start;
  logic [bxavg_pkg::PIX_W-1:0]  pixel_red;
  logic [bxavg_pkg::PIX_W-1:0]  pixel_green;
  logic [bxavg_pkg::PIX_W-1:0]  pixel_blue;

  modport source (output valid, frame_start, pixel_red, pixel_green, pixel_blue,
                  input ready);
  modport sink   (input valid, frame_start, pixel_red, pixel_green, pixel_blue,
                  output ready);
endinterface

interface bxavg_avg_if;
  logic                         valid;
  logic                         ready;
  logic [bxavg_pkg::PIX_W-1:0]  avg_red;
  logic [bxavg_pkg::PIX_W-1:0]  avg_green;
  logic [bxavg_pkg::PIX_W-1:0]  avg_blue;
  logic                         row_end;

  modport source (output valid, avg_red, avg_green, avg_blue, row_end, input ready);
  modport sink   (input valid, avg_red, avg_green, avg_blue, row_end, output ready);
endinterface

`default_nettype wire

/* design/bxavg_ram.sv */
`default_nettype none

module bxavg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/bxavg_div.sv */
`default_nettype none

module bxavg_div #(
  parameter int NW  = 16,
  parameter int DVW = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [bxavg_pkg::CH_N-1:0][NW-1:0]   num,
  input  wire logic [DVW-1:0]                       den,
  output      logic                                 busy,
  output      logic                                 done,
  output      logic [bxavg_pkg::CH_N-1:0][NW-1:0]   quot,
  output      logic [bxavg_pkg::CH_N-1:0][DVW-1:0]  rem
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0]                         cnt;
  logic [DVW-1:0]                        den_q;
  logic [bxavg_pkg::CH_N-1:0][DVW:0]     part;
  logic [bxavg_pkg::CH_N-1:0][DVW:0]     diff;
  logic [bxavg_pkg::CH_N-1:0]            ge;

  assign busy = (cnt != '0);

  // One restoring step per lane: shift in the next dividend bit, try a subtract
  always_comb begin
    for (int i = 0; i < bxavg_pkg::CH_N; i++) begin
      part[i] = {rem[i], quot[i][NW-1]};
      ge[i]   = (part[i] >= {1'b0, den_q});
      diff[i] = part[i] - {1'b0, den_q};
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(NW);
      end else if (busy) begin
        cnt  <= cnt - CW'(1);
        done <= (cnt == CW'(1));
      end
    end
  end

  // Quotient shifts in from the bottom while the dividend leaves at the top
  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      for (int i = 0; i < bxavg_pkg::CH_N; i++) begin
        rem[i]  <= ge[i] ? diff[i][DVW-1:0] : part[i][DVW-1:0];
        quot[i] <= {quot[i][NW-2:0], ge[i]};
      end
    end
  end

endmodule

`default_nettype wire

/* design/bxavg_dp.sv */
`default_nettype none

module bxavg_dp #(
  parameter int MAX_WIDTH  = bxavg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = bxavg_pkg::MAX_FACTOR_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [bxavg_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  wire logic [bxavg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                               frame_start,
  input  wire logic [bxavg_pkg::PIX_W-1:0]        pixel_red,
  input  wire logic [bxavg_pkg::PIX_W-1:0]        pixel_green,
  input  wire logic [bxavg_pkg::PIX_W-1:0]        pixel_blue,
  output      logic [bxavg_pkg::PIX_W-1:0]        avg_red,
  output      logic [bxavg_pkg::PIX_W-1:0]        avg_green,
  output      logic [bxavg_pkg::PIX_W-1:0]        avg_blue,
  output      logic                               row_end,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire bxavg_pkg::cmd_t                    cmd,
  output      bxavg_pkg::stat_t                   stat
);

  localparam int TW  = $clog2(MAX_FACTOR + 1);
  localparam int TW1 = TW + 1;
  localparam int PW  = $clog2(MAX_FACTOR);
  localparam int PCW = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int SW  = $clog2(MAX_FACTOR * MAX_FACTOR * ((1 << bxavg_pkg::PIX_W) - 1) + 1);
  localparam int NW  = (SW > WW) ? SW : WW;
  localparam int DVW = 2 * TW;
  localparam int CH  = bxavg_pkg::CH_N;

  // Configuration registers
  logic [bxavg_pkg::FACTOR_REG_W-1:0] block_factor;
  logic [bxavg_pkg::WIDTH_REG_W-1:0]  image_width;
  logic [TW-1:0]                      t_eff;
  logic [WW-1:0]                      w_eff;
  logic [DVW-1:0]                     tsq;

  // Position and sum state
  logic [PCW-1:0]          pc, pc_b;
  logic [PCW-1:0]          pq, pq_b;
  logic [PW-1:0]           pr, pr_b;
  logic [PW-1:0]           cp, cp_b;
  logic [PW-1:0]           rp, rp_b;
  logic [WW-1:0]           bpr;
  logic [CH-1:0][SW-1:0]   hsum, hs_b, hs_add, col, blk_sum;
  logic [CH-1:0][bxavg_pkg::PIX_W-1:0] pix_ch;
  logic                    row_end_pend;

  // Column accumulator access
  logic [CH-1:0][SW-1:0]   rd;
  logic [PCW-1:0]          rd_addr_q;
  logic                    we, we_q;

  logic                    complete, last_row, row_wrap, pr_wrap, blk_last;

  // Divider
  logic [CH-1:0][NW-1:0]   div_num, quot;
  logic [CH-1:0][DVW-1:0]  rem;
  logic [DVW-1:0]          div_den;
  logic                    div_busy, div_done;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_factor <= bxavg_pkg::FACTOR_RESET;
      image_width  <= bxavg_pkg::WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bxavg_pkg::REG_BLOCK_FACTOR: block_factor <= cfg_data[bxavg_pkg::FACTOR_REG_W-1:0];
        bxavg_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[bxavg_pkg::WIDTH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp factor and width into their usable ranges
  always_comb begin
    if (block_factor == '0) begin
      t_eff = TW'(1);
    end else if (int'(block_factor) > MAX_FACTOR) begin
      t_eff = TW'(MAX_FACTOR);
    end else begin
      t_eff = TW'(block_factor);
    end
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    tsq = DVW'(t_eff) * DVW'(t_eff);
  end

  assign pix_ch = {pixel_blue, pixel_green, pixel_red};

  // Per-beat arithmetic; a frame start clears position and sums first
  always_comb begin
    cp_b = frame_start ? '0 : cp;
    rp_b = frame_start ? '0 : rp;
    pc_b = frame_start ? '0 : pc;
    pq_b = frame_start ? '0 : pq;
    pr_b = frame_start ? '0 : pr;
    for (int i = 0; i < CH; i++) begin
      hs_b[i]    = frame_start ? '0 : hsum[i];
      hs_add[i]  = hs_b[i] + SW'(pix_ch[i]);
      col[i]     = (rp_b != '0) ? rd[i] : '0;
      blk_sum[i] = hs_add[i] + col[i];
    end
    complete = (TW1'(cp_b) + TW1'(1)) >= TW1'(t_eff);
    last_row = (TW1'(rp_b) + TW1'(1)) >= TW1'(t_eff);
    row_wrap = (WW'(pc_b) + WW'(1)) >= w_eff;
    pr_wrap  = (TW'(pr_b) + TW'(1)) == t_eff;
    blk_last = (WW'(pq_b) + WW'(1)) == bpr;
    we       = cmd.pix_accept && complete && !last_row;
  end

  // Advance position counters and horizontal sums, or load the refreshed block position
  always_ff @(posedge clk) begin
    if (rst) begin
      cp   <= '0;
      rp   <= '0;
      pc   <= '0;
      pq   <= '0;
      pr   <= '0;
      bpr  <= '0;
      hsum <= '0;
    end else if (cmd.pix_accept) begin
      hsum <= (complete || row_wrap) ? '0 : hs_add;
      cp   <= (complete || row_wrap) ? '0 : PW'(cp_b + PW'(1));
      if (row_wrap) begin
        pc <= '0;
        pq <= '0;
        pr <= '0;
        rp <= last_row ? '0 : PW'(rp_b + PW'(1));
      end else begin
        pc <= pc_b + PCW'(1);
        rp <= rp_b;
        if (pr_wrap) begin
          pq <= pq_b + PCW'(1);
          pr <= '0;
        end else begin
          pq <= pq_b;
          pr <= pr_b + PW'(1);
        end
      end
    end else if (cmd.cfg_load) begin
      pq  <= quot[0][PCW-1:0];
      pr  <= rem[0][PW-1:0];
      bpr <= quot[1][WW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_accept) begin
      row_end_pend <= blk_last;
    end
  end

  // Track whether the registered read matches the current block column
  always_ff @(posedge clk) begin
    if (rst) begin
      we_q <= 1'b1;
    end else begin
      we_q <= we;
    end
    rd_addr_q <= pq;
  end

  bxavg_ram #(
    .WIDTH (CH * SW),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (we),
    .waddr (pq_b),
    .wdata (blk_sum),
    .raddr (pq),
    .rdata (rd)
  );

  // Divider operands: block sums by factor squared, or position and width by factor
  always_comb begin
    if (cmd.div_cfg) begin
      div_num[0] = NW'(pc);
      div_num[1] = NW'(w_eff);
      div_num[2] = '0;
      div_den    = DVW'(t_eff);
    end else begin
      for (int i = 0; i < CH; i++) begin
        div_num[i] = NW'(blk_sum[i]);
      end
      div_den = tsq;
    end
  end

  bxavg_div #(
    .NW  (NW),
    .DVW (DVW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot),
    .rem   (rem)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      avg_red   <= quot[0][bxavg_pkg::PIX_W-1:0];
      avg_green <= quot[1][bxavg_pkg::PIX_W-1:0];
      avg_blue  <= quot[2][bxavg_pkg::PIX_W-1:0];
      row_end   <= row_end_pend;
    end
  end

  // Status back to the controller
  always_comb begin
    stat.rd_ok    = (rd_addr_q == pq) && !we_q;
    stat.out_fire = complete && last_row;
    stat.div_busy = div_busy;
    stat.div_done = div_done;
    stat.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

/* design/bxavg_ctrl.sv */
`default_nettype none

module bxavg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              pix_valid,
  output      logic              pix_ready,
  input  wire bxavg_pkg::stat_t  stat,
  output      bxavg_pkg::cmd_t   cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CFGDIV = 2'd1;
  localparam logic [1:0] S_OUTDIV = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  logic [1:0] state, state_next;
  logic       pend, pend_next;

  // Take a beat only when idle, settled and the column read is current
  assign pix_ready = (state == S_IDLE) && !pend && stat.rd_ok;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.pix_accept = pix_ready && pix_valid;
    unique case (state)
      S_IDLE: begin
        if (cmd.pix_accept && stat.out_fire) begin
          cmd.div_start = 1'b1;
          state_next    = S_OUTDIV;
        end else if (pend) begin
          cmd.div_start = 1'b1;
          cmd.div_cfg   = 1'b1;
          state_next    = S_CFGDIV;
        end
      end
      S_CFGDIV: begin
        if (pend) begin
          cmd.div_start = 1'b1;
          cmd.div_cfg   = 1'b1;
        end else if (stat.div_done) begin
          cmd.cfg_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_OUTDIV: begin
        if (stat.div_done) begin
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
    // Hold a recompute request until its division starts
    if (cfg_we) begin
      pend_next = 1'b1;
    end else if (cmd.div_start && cmd.div_cfg) begin
      pend_next = 1'b0;
    end else begin
      pend_next = pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b1;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  a_fire_divides: assert property (@(posedge clk) disable iff (rst)
    (cmd.pix_accept && stat.out_fire) |=> (state == S_OUTDIV))
    else $error("block result did not start a division");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten");

  a_pend_blocks: assert property (@(posedge clk) disable iff (rst)
    pend |-> !cmd.pix_accept)
    else $error("pixel taken before recompute");

  a_hold_idle_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> !stat.div_busy)
    else $error("divider busy while result held");

endmodule

`default_nettype wire

/* design/box_average_downscale.sv */
// Box-average downscaler for an RGB raster stream.
// Pixels enter on the pixels channel (valid/ready) in raster order; frame_start
// on a beat restarts the position counters. Every full block of factor x factor
// pixels yields one beat on the averages channel holding the truncated per-channel
// mean; row_end marks the last block of an output row. Incomplete blocks at the
// right and bottom edges give no output.
// Throughput: one pixel per cycle inside a block row while the controller is idle;
// a beat that closes a block column, wraps a row or starts a frame can stall input,
// because the column accumulator RAM read is registered and must catch up with the new column.
// A pixel that closes a whole block also runs the shared shift-subtract divider,
// one quotient bit per cycle: 16 steps with the default limits (sum width). The
// result goes to the output register once the divider is done, and input is held
// while that division runs.
// The output register lets the next pixel in while a result waits; if a new
// result finishes while the receiver still stalls, input stops until it drains.
// Configuration writes (block_factor, image_width) re-run the divider to refresh
// the block position and blocks per row; input is held until that refresh is loaded.
// Reset sets factor 2 and width 512 and runs that same refresh before the first
// pixel is taken; the accumulator RAM is not cleared.
`default_nettype none

module box_average_downscale #(
  parameter int MAX_WIDTH  = bxavg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = bxavg_pkg::MAX_FACTOR_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  bxavg_pix_if.sink                              pixels,
  bxavg_avg_if.source                            averages,
  input  wire logic                              cfg_we,
  input  wire logic [bxavg_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  wire logic [bxavg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bxavg_pkg::cmd_t  cmd;
  bxavg_pkg::stat_t stat;
  logic             pix_ready;
  logic             out_valid;
  logic [bxavg_pkg::PIX_W-1:0] avg_red, avg_green, avg_blue;
  logic             row_end;

  bxavg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .pix_valid (pixels.valid),
    .pix_ready (pix_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bxavg_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .frame_start (pixels.frame_start),
    .pixel_red   (pixels.pixel_red),
    .pixel_green (pixels.pixel_green),
    .pixel_blue  (pixels.pixel_blue),
    .avg_red     (avg_red),
    .avg_green   (avg_green),
    .avg_blue    (avg_blue),
    .row_end     (row_end),
    .out_valid   (out_valid),
    .out_ready   (averages.ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  // Drive the channel ports
  assign pixels.ready       = pix_ready;
  assign averages.valid     = out_valid;
  assign averages.avg_red   = avg_red;
  assign averages.avg_green = avg_green;
  assign averages.avg_blue  = avg_blue;
  assign averages.row_end   = row_end;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;
  import bxavg_pkg::*;

  typedef struct packed {
    logic             frame_start;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             row_end;
  } block_avg_t;

  // Settle time after the last result (divider run plus output register)
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bxavg_pix_if pix_ch ();
  bxavg_avg_if avg_ch ();

  box_average_downscale u_top (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pix_ch),
    .averages  (avg_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  pixel_t     pixel_q[$];
  block_avg_t block_avg_q[$];
  int         fail_count = 0;
  int         results_seen = 0;
  int         quiet_cycles = 0;
  bit         pixel_took = 1'b0;
  int         send_gap_pct;
  int         recv_stall_pct;

  // Shadow of the scaler: registers, line of column sums, running row-segment sums
  logic [FACTOR_REG_W-1:0] factor_reg = FACTOR_RESET;
  logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
  int unsigned col_sum_red   [MAX_WIDTH_DEF];
  int unsigned col_sum_green [MAX_WIDTH_DEF];
  int unsigned col_sum_blue  [MAX_WIDTH_DEF];
  int unsigned seg_sum [3] = '{0, 0, 0};
  int unsigned pix_col   = 0;
  int unsigned col_phase = 0;
  int unsigned row_phase = 0;

  function automatic int unsigned scale_factor();
    if (factor_reg == 0) return 1;
    if (factor_reg > MAX_FACTOR_DEF) return MAX_FACTOR_DEF;
    return factor_reg;
  endfunction

  function automatic int unsigned row_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Advance the shadow by one pixel; queue a block average when a block closes
  function automatic void predict_pixel(input pixel_t p);
    int unsigned t;
    int unsigned w;
    int unsigned blk;
    int unsigned area;
    int unsigned sum [3];
    block_avg_t  avg;
    t = scale_factor();
    w = row_width();
    if (p.frame_start) begin
      pix_col   = 0;
      col_phase = 0;
      row_phase = 0;
      seg_sum   = '{0, 0, 0};
    end
    seg_sum[0] += p.red;
    seg_sum[1] += p.green;
    seg_sum[2] += p.blue;
    if (col_phase + 1 >= t) begin
      blk = (pix_col / t) % MAX_WIDTH_DEF;
      sum = seg_sum;
      if (row_phase != 0) begin
        sum[0] += col_sum_red[blk];
        sum[1] += col_sum_green[blk];
        sum[2] += col_sum_blue[blk];
      end
      if (row_phase + 1 >= t) begin
        area        = t * t;
        avg.red     = PIX_W'(sum[0] / area);
        avg.green   = PIX_W'(sum[1] / area);
        avg.blue    = PIX_W'(sum[2] / area);
        avg.row_end = (blk + 1 == w / t);
        block_avg_q.push_back(avg);
      end else begin
        col_sum_red[blk]   = sum[0];
        col_sum_green[blk] = sum[1];
        col_sum_blue[blk]  = sum[2];
      end
      seg_sum   = '{0, 0, 0};
      col_phase = 0;
    end else begin
      col_phase++;
    end
    if (pix_col + 1 >= w) begin
      pix_col   = 0;
      col_phase = 0;
      seg_sum   = '{0, 0, 0};
      row_phase = (row_phase + 1 >= t) ? 0 : row_phase + 1;
    end else begin
      pix_col++;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  // Monitor: check result beats, feed accepted pixel beats to the shadow, watchdog
  always @(posedge clk) begin
    block_avg_t got;
    block_avg_t want;
    pixel_t     p;
    if (rst) begin
      pixel_took   = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (avg_ch.valid && avg_ch.ready) begin
        got = '{avg_ch.avg_red, avg_ch.avg_green, avg_ch.avg_blue, avg_ch.row_end};
        if (block_avg_q.size() == 0) begin
          report_mismatch($sformatf("block average %0d arrived with none pending: %p",
                                    results_seen, got));
        end else begin
          want = block_avg_q.pop_front();
          if (got.red !== want.red)
            report_mismatch($sformatf("block average %0d red %0d, want %0d",
                                      results_seen, got.red, want.red));
          if (got.green !== want.green)
            report_mismatch($sformatf("block average %0d green %0d, want %0d",
                                      results_seen, got.green, want.green));
          if (got.blue !== want.blue)
            report_mismatch($sformatf("block average %0d blue %0d, want %0d",
                                      results_seen, got.blue, want.blue));
          if (got.row_end !== want.row_end)
            report_mismatch($sformatf("block average %0d row_end %0b, want %0b",
                                      results_seen, got.row_end, want.row_end));
        end
        results_seen++;
      end
      pixel_took = pix_ch.valid && pix_ch.ready;
      if (pixel_took) begin
        p = '{pix_ch.frame_start, pix_ch.pixel_red, pix_ch.pixel_green, pix_ch.pixel_blue};
        predict_pixel(p);
      end
      if (pixel_took || (avg_ch.valid && avg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // Driver: hold an unaccepted beat, else send the next pixel or idle
  always @(negedge clk) begin
    pixel_t p;
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else if (pix_ch.valid && !pixel_took) begin
      // hold
    end else if (pixel_q.size() != 0 && !roll(send_gap_pct)) begin
      p = pixel_q.pop_front();
      pix_ch.valid       <= 1'b1;
      pix_ch.frame_start <= p.frame_start;
      pix_ch.pixel_red   <= p.red;
      pix_ch.pixel_green <= p.green;
      pix_ch.pixel_blue  <= p.blue;
    end else begin
      pix_ch.valid <= 1'b0;
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    if (rst) begin
      avg_ch.ready <= 1'b0;
    end else begin
      avg_ch.ready <= !roll(recv_stall_pct);
    end
  end

  // Write one register once the block has settled
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned value);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BLOCK_FACTOR) factor_reg = FACTOR_REG_W'(value);
    else width_reg = WIDTH_REG_W'(value);
  endtask

  task automatic load_config(input int unsigned factor, input int unsigned width);
    write_reg(REG_BLOCK_FACTOR, factor);
    write_reg(REG_IMAGE_WIDTH, width);
  endtask

  function automatic void push_pixel(input bit fs, input int r, input int g, input int b);
    pixel_q.push_back('{fs, PIX_W'(r), PIX_W'(g), PIX_W'(b)});
  endfunction

  // Queue count pixels as frames of block rows, some with a partial bottom row,
  // with an occasional stray frame start
  task automatic queue_frames(input int unsigned count);
    int unsigned t;
    int unsigned w;
    int unsigned rows;
    int unsigned n_frame;
    pixel_t      p;
    t = scale_factor();
    w = row_width();
    while (count > 0) begin
      rows = t * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) rows += $urandom_range(0, t - 1);
      n_frame = rows * w;
      for (int unsigned i = 0; i < n_frame && count > 0; i++) begin
        p.frame_start = (i == 0) || ($urandom_range(0, 49) == 0);
        case ($urandom_range(0, 15))
          0: begin
            p.red = '0; p.green = '0; p.blue = '0;
          end
          1: begin
            p.red = '1; p.green = '1; p.blue = '1;
          end
          default: begin
            p.red   = PIX_W'($urandom_range(0, 255));
            p.green = PIX_W'($urandom_range(0, 255));
            p.blue  = PIX_W'($urandom_range(0, 255));
          end
        endcase
        pixel_q.push_back(p);
        count--;
      end
    end
  endtask

  // Wait until every pixel is taken and every block average has arrived
  task automatic drain();
    while (pixel_q.size() != 0 || pix_ch.valid || block_avg_q.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int unsigned f;
    int unsigned w;
    int unsigned n;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_BLOCK_FACTOR;
    cfg_data           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.frame_start = 1'b0;
    pix_ch.pixel_red   = '0;
    pix_ch.pixel_green = '0;
    pix_ch.pixel_blue  = '0;
    avg_ch.ready       = 1'b0;
    send_gap_pct       = 15;
    recv_stall_pct     = 52;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Factor 2 on a 5-pixel row: the fifth column is a dropped right edge
    load_config(2, 5);
    push_pixel(1, 255, 255, 255);
    push_pixel(0, 255,   0, 255);
    push_pixel(0,   0,   0,   0);
    push_pixel(0,   1, 128,   0);
    push_pixel(0,   7,   7,   7);
    push_pixel(0, 255, 255, 255);
    push_pixel(0, 254, 255,   0);
    push_pixel(0,   0,   0,   0);
    push_pixel(0, 255, 127,   1);
    push_pixel(0,   9,   9,   9);
    // Partial bottom row, then a new frame discards it
    push_pixel(0, 200, 200, 200);
    push_pixel(0, 100, 100, 100);
    push_pixel(0,  50,  50,  50);
    push_pixel(1, 8'h55, 8'hAA, 8'h55);
    push_pixel(0, 8'hAA, 8'h55, 8'hAA);
    push_pixel(0, 8'h0F, 8'hF0, 8'h33);
    push_pixel(0, 8'hF0, 8'h0F, 8'hCC);
    push_pixel(0, 8'h80, 8'h01, 8'h7F);
    // Second pixel row of the frame continues without a frame start
    push_pixel(0, 8'h01, 8'h80, 8'hFE);
    push_pixel(0, 8'hFF, 8'hFF, 8'h00);
    push_pixel(0, 8'h00, 8'hFF, 8'hFF);
    push_pixel(0, 8'hFE, 8'h02, 8'h40);
    push_pixel(0, 8'h03, 8'hFD, 8'h20);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 5) begin
        send_gap_pct   = 52;
        recv_stall_pct = 15;
      end else if (ph == 10) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      f = $urandom_range(1, 6);
      w = $urandom_range(1, 24);
      n = $urandom_range(30, 60);
      case (ph)
        // factor zero acts as one
        0: begin f = 0;  w = 3;    n = 60;   end
        // factor above the limit: 16x16 blocks with a ragged right edge
        2: begin f = 31; w = 17;   n = 290;  end
        // width zero acts as one; factor 2 can never close a block
        4: begin f = 2;  w = 0;    n = 20;   end
        6: begin f = 1;  w = 0;    n = 30;   end
        // width above the limit: full 1024-pixel rows
        7: begin f = 1;  w = 2047; n = 1030; end
        // factor exceeds width: no block ever completes
        11: begin f = 16; w = 9;   n = 40;   end
        default: ;
      endcase
      load_config(f, w);
      queue_frames(n);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
